@@ hw/rtl/qtd_pkg.sv @@
// Shared types and constants for the quadtree image decoder.
// No dependencies; imported by every module of the block.
package qtd_pkg;

  localparam int SIDE_W          = 4;
  localparam int COORD_W         = 10;
  localparam int COLOR_W         = 8;
  localparam int MAX_SIDE_LOG2_D = 10;
  localparam int CMDQ_DEPTH      = 2;

  localparam logic [COLOR_W-1:0] TAG_FILL  = 8'd0;
  localparam logic [COLOR_W-1:0] TAG_SPLIT = 8'd1;

  typedef enum logic [1:0] {
    OP_SPLIT,
    OP_SKIP,
    OP_LEAF
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } cmd_t;

endpackage

@@ hw/rtl/qtd_front.sv @@
// Byte parser: turns the tree byte stream into split, skip and leaf commands.
// Depends on qtd_pkg.
module qtd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        byte_valid_i,
  input  logic [qtd_pkg::COLOR_W-1:0] byte_i,
  output logic                        cmd_push_o,
  output qtd_pkg::cmd_t               cmd_o
);
  import qtd_pkg::*;

  localparam logic [1:0] PH_TAG   = 2'd0;
  localparam logic [1:0] PH_RED   = 2'd1;
  localparam logic [1:0] PH_GREEN = 2'd2;
  localparam logic [1:0] PH_BLUE  = 2'd3;

  logic [1:0]         phase_q, phase_d;
  logic [COLOR_W-1:0] red_q, red_d;
  logic [COLOR_W-1:0] green_q, green_d;

  always_comb begin
    phase_d    = phase_q;
    red_d      = red_q;
    green_d    = green_q;
    cmd_push_o = 1'b0;
    cmd_o.op    = OP_SKIP;
    cmd_o.red   = red_q;
    cmd_o.green = green_q;
    cmd_o.blue  = byte_i;
    if (byte_valid_i) begin
      case (phase_q)
        PH_TAG: begin
          if (byte_i == TAG_FILL) begin
            phase_d = PH_RED;
          end else begin
            cmd_push_o = 1'b1;
            cmd_o.op   = (byte_i == TAG_SPLIT) ? OP_SPLIT : OP_SKIP;
          end
        end
        PH_RED: begin
          red_d   = byte_i;
          phase_d = PH_GREEN;
        end
        PH_GREEN: begin
          green_d = byte_i;
          phase_d = PH_BLUE;
        end
        default: begin
          cmd_push_o = 1'b1;
          cmd_o.op   = OP_LEAF;
          phase_d    = PH_TAG;
        end
      endcase
    end
    if (cfg_we_i) begin
      phase_d = PH_TAG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      red_q   <= '0;
      green_q <= '0;
    end else begin
      phase_q <= phase_d;
      red_q   <= red_d;
      green_q <= green_d;
    end
  end

endmodule

@@ hw/rtl/qtd_cmd_fifo.sv @@
// Short command queue between the parser and the tree walker.
// Depends on qtd_pkg.
module qtd_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  qtd_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output qtd_pkg::cmd_t rdata_o
);
  import qtd_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMDQ_DEPTH - 1);

  cmd_t             mem_q [CMDQ_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(CMDQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/qtd_back.sv @@
// Tree walker: quadrant stack, block position and the registered result word.
// Depends on qtd_pkg.
module qtd_back #(
  parameter int MAX_SIDE_LOG2 = qtd_pkg::MAX_SIDE_LOG2_D
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [qtd_pkg::SIDE_W-1:0]  cfg_wdata_i,
  input  logic                        cmd_valid_i,
  input  qtd_pkg::cmd_t               cmd_i,
  output logic                        cmd_pop_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [qtd_pkg::COORD_W-1:0] block_x_o,
  output logic [qtd_pkg::COORD_W-1:0] block_y_o,
  output logic [qtd_pkg::SIDE_W-1:0]  block_size_log2_o,
  output logic [qtd_pkg::COLOR_W-1:0] fill_red_o,
  output logic [qtd_pkg::COLOR_W-1:0] fill_green_o,
  output logic [qtd_pkg::COLOR_W-1:0] fill_blue_o,
  output logic                        image_done_o
);
  import qtd_pkg::*;

  localparam int DEPTH_W = $clog2(MAX_SIDE_LOG2 + 1);
  localparam int WIDE_W  = MAX_SIDE_LOG2 + COORD_W;

  logic [SIDE_W-1:0]        side_q;
  logic [DEPTH_W-1:0]       depth_q, depth_d;
  logic [1:0]               stack_q [MAX_SIDE_LOG2];
  logic [1:0]               stack_d [MAX_SIDE_LOG2];
  logic                     out_valid_q, out_valid_d;

  logic [DEPTH_W-1:0]       s_eff, depth_c, find_k, shamt;
  logic                     found;
  logic [MAX_SIDE_LOG2-1:0] xv, yv;
  logic [WIDE_W-1:0]        x_wide, y_wide;
  logic                     pop_ok, leaf_fire;

  assign s_eff   = (side_q > SIDE_W'(MAX_SIDE_LOG2)) ? DEPTH_W'(MAX_SIDE_LOG2)
                                                     : DEPTH_W'(side_q);
  assign depth_c = (depth_q > s_eff) ? s_eff : depth_q;
  assign shamt   = DEPTH_W'(MAX_SIDE_LOG2) - s_eff;

  assign empty     = !out_valid_q;
  assign pop_ok    = pop && out_valid_q;
  assign cmd_pop_o = cmd_valid_i && ((cmd_i.op != OP_LEAF) || !out_valid_q || pop);
  assign leaf_fire = cmd_pop_o && (cmd_i.op == OP_LEAF);

  // Deepest level that still has a sibling to visit.
  always_comb begin
    found  = 1'b0;
    find_k = '0;
    for (int k = 0; k < MAX_SIDE_LOG2; k++) begin
      if ((k < int'(depth_c)) && (stack_q[k] != 2'd3)) begin
        found  = 1'b1;
        find_k = DEPTH_W'(k);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_SIDE_LOG2; k++) begin
      xv[MAX_SIDE_LOG2-1-k] = (k < int'(depth_c)) && stack_q[k][0];
      yv[MAX_SIDE_LOG2-1-k] = (k < int'(depth_c)) && stack_q[k][1];
    end
  end

  assign x_wide = {{COORD_W{1'b0}}, xv} >> shamt;
  assign y_wide = {{COORD_W{1'b0}}, yv} >> shamt;

  always_comb begin
    depth_d     = depth_c;
    out_valid_d = out_valid_q;
    for (int k = 0; k < MAX_SIDE_LOG2; k++) begin
      stack_d[k] = stack_q[k];
    end
    if (pop_ok) begin
      out_valid_d = 1'b0;
    end
    if (cmd_pop_o) begin
      if ((cmd_i.op == OP_SPLIT) && (depth_c < s_eff)) begin
        for (int k = 0; k < MAX_SIDE_LOG2; k++) begin
          if (k == int'(depth_c)) begin
            stack_d[k] = 2'd0;
          end
        end
        depth_d = depth_c + 1'b1;
      end else begin
        for (int k = 0; k < MAX_SIDE_LOG2; k++) begin
          if (found && (k == int'(find_k))) begin
            stack_d[k] = stack_q[k] + 2'd1;
          end
        end
        depth_d = found ? find_k + 1'b1 : '0;
      end
      if (leaf_fire) begin
        out_valid_d = 1'b1;
      end
    end
    if (cfg_we_i) begin
      depth_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q      <= SIDE_W'(10);
      depth_q     <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < MAX_SIDE_LOG2; k++) begin
        stack_q[k] <= 2'd0;
      end
    end else begin
      if (cfg_we_i) begin
        side_q <= cfg_wdata_i;
      end
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
      for (int k = 0; k < MAX_SIDE_LOG2; k++) begin
        stack_q[k] <= stack_d[k];
      end
    end
  end

  // Result word; payload only, no reset.
  always_ff @(posedge clk_i) begin
    if (leaf_fire) begin
      block_x_o         <= x_wide[COORD_W-1:0];
      block_y_o         <= y_wide[COORD_W-1:0];
      block_size_log2_o <= SIDE_W'(s_eff - depth_c);
      fill_red_o        <= cmd_i.red;
      fill_green_o      <= cmd_i.green;
      fill_blue_o       <= cmd_i.blue;
      image_done_o      <= !found;
    end
  end

endmodule

@@ hw/rtl/quadtree_image_decoder.sv @@
// Top level of the quadtree image decoder: parser, command queue, tree walker.
// Depends on qtd_pkg, qtd_front, qtd_cmd_fifo and qtd_back.
//
//   channel   handshake          word
//   input     push / full        tree_byte_i
//   config    cfg_we_i           cfg_wdata_i (side_log2)
//   result    empty / pop        block_x_o .. image_done_o
//
// One tree byte is taken every cycle while full is low; the parser never stalls
// on its own. A leaf reaches the result ports via the queue and the result word.
// The walker takes one command a cycle; it holds a leaf only while the single
// result word is occupied and not popped, and the two-entry queue absorbs that.
// Reset: side_log2 = 10, walk at the root, parser expecting a tag.
module quadtree_image_decoder #(
  parameter int MAX_SIDE_LOG2 = qtd_pkg::MAX_SIDE_LOG2_D
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [qtd_pkg::SIDE_W-1:0]  cfg_wdata_i,
  input  logic                        push,
  output logic                        full,
  input  logic [qtd_pkg::COLOR_W-1:0] tree_byte_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [qtd_pkg::COORD_W-1:0] block_x_o,
  output logic [qtd_pkg::COORD_W-1:0] block_y_o,
  output logic [qtd_pkg::SIDE_W-1:0]  block_size_log2_o,
  output logic [qtd_pkg::COLOR_W-1:0] fill_red_o,
  output logic [qtd_pkg::COLOR_W-1:0] fill_green_o,
  output logic [qtd_pkg::COLOR_W-1:0] fill_blue_o,
  output logic                        image_done_o
);
  import qtd_pkg::*;

  logic byte_valid;
  logic cmd_push, cmd_pop, cmd_valid;
  cmd_t cmd_wr, cmd_rd;

  assign byte_valid = push && !full;

  qtd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .byte_valid_i (byte_valid),
    .byte_i       (tree_byte_i),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_wr)
  );

  qtd_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wr),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .rdata_o (cmd_rd)
  );

  qtd_back #(
    .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (cmd_rd),
    .cmd_pop_o         (cmd_pop),
    .empty             (empty),
    .pop               (pop),
    .block_x_o         (block_x_o),
    .block_y_o         (block_y_o),
    .block_size_log2_o (block_size_log2_o),
    .fill_red_o        (fill_red_o),
    .fill_green_o      (fill_green_o),
    .fill_blue_o       (fill_blue_o),
    .image_done_o      (image_done_o)
  );

endmodule
